FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

FILE: sv/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
    localparam logic [3:0]  BYTE_BITS         = 4'd8;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUS_BUSY  = 2'd1;
    localparam logic [1:0] ST_BUS_ERROR = 2'd2;
    localparam logic [1:0] ST_ADDR_NACK = 2'd3;

    // Sequencer phase; a 3-bit sub-step runs inside each phase.
    typedef enum logic [2:0] {
        P_CTRL   = 3'd0,  // idle and stop condition
        P_START  = 3'd1,
        P_ADDR   = 3'd2,
        P_REG    = 3'd3,
        P_DATA   = 3'd4,
        P_RSTART = 3'd5,
        P_RADDR  = 3'd6,
        P_READ   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] slave_address;
        logic [7:0] reg_index;
        logic [7:0] write_data;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] read_data;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/i2c_master_register_access_core.sv
`default_nettype none

`include "assert_macros.svh"

// I2C master for single-byte register write and read. Each transfer on the
// cmd channel is one bus tick carrying the sampled SDA level and, while the
// core is idle, a request (write: start, address, register, data, stop;
// read: start, address, register, repeated start, address plus one, eight
// read bits, NACK, stop). Every transfer produces exactly one result transfer
// with the SCL/SDA drive, busy, a one-tick done pulse, status and read data.
// One tick is accepted per clock cycle: the sequencer state register updates
// once per tick and the result sits in an output register, so the only
// stall is a full output register that is not being taken. Every line
// change is followed by half_period_ticks idle ticks, set through the cfg
// write channel (reset value 10); write it only while the core is idle.
module i2c_master_register_access_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,

    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [15:0]    cfg_data,

    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire i2cm_pkg::cmd_t cmd_data,

    output logic                res_valid,
    input  wire logic           res_stall,
    output i2cm_pkg::res_t      res_data
);

    logic [15:0]                      half_period_reg;
    i2cm_pkg::phase_t                 phase_reg, phase_next;
    logic [2:0]                       sub_reg, sub_next;
    logic [i2cm_pkg::COUNT_WIDTH-1:0] wait_reg, wait_next;
    logic [3:0]                       bit_cnt_reg, bit_cnt_next;
    logic [7:0]                       shift_reg, shift_next;
    logic [7:0]                       slave_reg, slave_next;
    logic [7:0]                       regaddr_reg, regaddr_next;
    logic [7:0]                       data_reg, data_next;
    logic                             is_read_reg, is_read_next;
    logic                             scl_reg, scl_next;
    logic                             sda_reg, sda_next;
    logic [1:0]                       status_reg, status_next;
    logic                             res_valid_reg;
    i2cm_pkg::res_t                   res_reg, res_next;

    logic cmd_accept;
    logic done;
    logic line_change;
    logic start_fail;
    logic idle;

    assign cfg_ready  = 1'b1;
    assign cmd_stall  = res_valid_reg & res_stall;
    assign cmd_accept = cmd_valid & ~cmd_stall;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_reg;
    assign idle       = (phase_reg == i2cm_pkg::P_CTRL) && (sub_reg == 3'd0);
    assign start_fail = ((sub_reg == 3'd1) && !cmd_data.sda_in)
                     || ((sub_reg == 3'd2) && cmd_data.sda_in);

    always_comb
    begin
        phase_next   = phase_reg;
        sub_next     = sub_reg;
        wait_next    = wait_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        slave_next   = slave_reg;
        regaddr_next = regaddr_reg;
        data_next    = data_reg;
        is_read_next = is_read_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        status_next  = status_reg;
        done         = 1'b0;
        line_change  = 1'b0;

        if (idle)
        begin
            if ((cmd_data.command == i2cm_pkg::CMD_WRITE)
                || (cmd_data.command == i2cm_pkg::CMD_READ))
            begin
                slave_next   = cmd_data.slave_address;
                regaddr_next = cmd_data.reg_index;
                data_next    = cmd_data.write_data;
                is_read_next = (cmd_data.command == i2cm_pkg::CMD_READ);
                status_next  = i2cm_pkg::ST_OK;
                shift_next   = 8'd0;
                bit_cnt_next = 4'd0;
                phase_next   = i2cm_pkg::P_START;
                sub_next     = 3'd1;
                scl_next     = 1'b1;
                sda_next     = 1'b1;
                line_change  = 1'b1;
            end
        end
        else if (wait_reg != '0)
        begin
            wait_next = wait_reg - i2cm_pkg::COUNT_WIDTH'(1);
        end
        else
        begin
            // Steps that change no line resolve first and fall into a line change.
            case (phase_reg)
                i2cm_pkg::P_CTRL:
                begin
                    if (sub_reg >= 3'd5)
                    begin
                        sub_next = 3'd0;
                        done     = 1'b1;
                    end
                end
                i2cm_pkg::P_START, i2cm_pkg::P_RSTART:
                begin
                    if (start_fail)
                    begin
                        if (phase_reg == i2cm_pkg::P_START)
                        begin
                            status_next = (sub_reg == 3'd1) ? i2cm_pkg::ST_BUS_BUSY
                                                            : i2cm_pkg::ST_BUS_ERROR;
                            phase_next  = i2cm_pkg::P_CTRL;
                            sub_next    = 3'd0;
                            done        = 1'b1;
                        end
                        else
                        begin
                            // repeated start failure is ignored
                            phase_next   = i2cm_pkg::P_RADDR;
                            sub_next     = 3'd0;
                            shift_next   = slave_reg + 8'd1;
                            bit_cnt_next = 4'd0;
                        end
                    end
                    else if (sub_reg >= 3'd3)
                    begin
                        phase_next   = (phase_reg == i2cm_pkg::P_START) ? i2cm_pkg::P_ADDR
                                                                        : i2cm_pkg::P_RADDR;
                        sub_next     = 3'd0;
                        shift_next   = (phase_reg == i2cm_pkg::P_START) ? slave_reg
                                                                        : slave_reg + 8'd1;
                        bit_cnt_next = 4'd0;
                    end
                end
                i2cm_pkg::P_READ:
                begin
                    if (sub_reg == 3'd2)
                    begin
                        shift_next   = {shift_reg[6:0], cmd_data.sda_in};
                        bit_cnt_next = bit_cnt_reg + 4'd1;
                        sub_next     = (bit_cnt_next >= i2cm_pkg::BYTE_BITS) ? 3'd3 : 3'd0;
                    end
                    else if (sub_reg == 3'd7)
                    begin
                        phase_next = i2cm_pkg::P_CTRL;
                        sub_next   = 3'd1;
                    end
                end
                default:
                begin
                    if (sub_reg == 3'd7)
                    begin
                        sub_next     = 3'd0;
                        bit_cnt_next = 4'd0;
                        case (phase_reg)
                            i2cm_pkg::P_ADDR:
                            begin
                                if (status_reg == i2cm_pkg::ST_ADDR_NACK)
                                begin
                                    phase_next = i2cm_pkg::P_CTRL;
                                    sub_next   = 3'd1;
                                end
                                else
                                begin
                                    phase_next = i2cm_pkg::P_REG;
                                    shift_next = regaddr_reg;
                                end
                            end
                            i2cm_pkg::P_REG:
                            begin
                                if (is_read_reg)
                                begin
                                    phase_next = i2cm_pkg::P_RSTART;
                                end
                                else
                                begin
                                    phase_next = i2cm_pkg::P_DATA;
                                    shift_next = data_reg;
                                end
                            end
                            i2cm_pkg::P_DATA:
                            begin
                                phase_next = i2cm_pkg::P_CTRL;
                                sub_next   = 3'd1;
                            end
                            default:
                            begin
                                phase_next = i2cm_pkg::P_READ;
                                shift_next = 8'd0;
                            end
                        endcase
                    end
                end
            endcase

            // Exactly one line change on the resolved step.
            if (!done)
            begin
                case (phase_next)
                    i2cm_pkg::P_CTRL:
                    begin
                        case (sub_next)
                            3'd1: begin scl_next = 1'b0; line_change = 1'b1; end
                            3'd2: begin sda_next = 1'b0; line_change = 1'b1; end
                            3'd3: begin scl_next = 1'b1; line_change = 1'b1; end
                            3'd4: begin sda_next = 1'b1; line_change = 1'b1; end
                            default: ;
                        endcase
                        if (line_change)
                            sub_next = sub_next + 3'd1;
                    end
                    i2cm_pkg::P_START, i2cm_pkg::P_RSTART:
                    begin
                        case (sub_next)
                            3'd0:
                            begin
                                scl_next    = 1'b1;
                                sda_next    = 1'b1;
                                line_change = 1'b1;
                            end
                            3'd1, 3'd2:
                            begin
                                sda_next    = 1'b0;
                                line_change = 1'b1;
                            end
                            default: ;
                        endcase
                        if (line_change)
                            sub_next = sub_next + 3'd1;
                    end
                    i2cm_pkg::P_READ:
                    begin
                        line_change = 1'b1;
                        case (sub_next)
                            3'd0:
                            begin
                                scl_next = 1'b0;
                                sda_next = 1'b1;
                                sub_next = 3'd1;
                            end
                            3'd1: begin scl_next = 1'b1; sub_next = 3'd2; end
                            3'd3: begin scl_next = 1'b0; sub_next = 3'd4; end
                            3'd4: begin sda_next = 1'b1; sub_next = 3'd5; end
                            3'd5: begin scl_next = 1'b1; sub_next = 3'd6; end
                            3'd6:
                            begin
                                scl_next   = 1'b0;
                                phase_next = i2cm_pkg::P_CTRL;
                                sub_next   = 3'd1;
                            end
                            default: line_change = 1'b0;
                        endcase
                    end
                    default:
                    begin
                        line_change = 1'b1;
                        case (sub_next)
                            3'd0: begin scl_next = 1'b0; sub_next = 3'd1; end
                            3'd1:
                            begin
                                sda_next   = shift_next[7];
                                shift_next = {shift_next[6:0], 1'b0};
                                sub_next   = 3'd2;
                            end
                            3'd2:
                            begin
                                bit_cnt_next = bit_cnt_next + 4'd1;
                                scl_next     = 1'b1;
                                sub_next     = (bit_cnt_next >= i2cm_pkg::BYTE_BITS) ? 3'd3
                                                                                     : 3'd0;
                            end
                            3'd3: begin scl_next = 1'b0; sub_next = 3'd4; end
                            3'd4: begin sda_next = 1'b1; sub_next = 3'd5; end
                            3'd5: begin scl_next = 1'b1; sub_next = 3'd6; end
                            3'd6:
                            begin
                                // only the first address acknowledge is checked
                                if ((phase_next == i2cm_pkg::P_ADDR) && cmd_data.sda_in)
                                    status_next = i2cm_pkg::ST_ADDR_NACK;
                                scl_next = 1'b0;
                                sub_next = 3'd7;
                            end
                            default: line_change = 1'b0;
                        endcase
                    end
                endcase
            end
        end

        if (line_change)
            wait_next = i2cm_pkg::COUNT_WIDTH'(half_period_reg);

        res_next.scl_out   = scl_next;
        res_next.sda_out   = sda_next;
        res_next.busy_res  = !((phase_next == i2cm_pkg::P_CTRL) && (sub_next == 3'd0));
        res_next.done_res  = done;
        res_next.status    = done ? status_next : i2cm_pkg::ST_OK;
        res_next.read_data = (done && is_read_next && (status_next == i2cm_pkg::ST_OK))
                           ? shift_next : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cm_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cm_pkg::P_CTRL;
            sub_reg     <= 3'd0;
            wait_reg    <= '0;
            bit_cnt_reg <= 4'd0;
            shift_reg   <= 8'd0;
            slave_reg   <= 8'd0;
            regaddr_reg <= 8'd0;
            data_reg    <= 8'd0;
            is_read_reg <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            status_reg  <= i2cm_pkg::ST_OK;
        end
        else if (cmd_accept)
        begin
            phase_reg   <= phase_next;
            sub_reg     <= sub_next;
            wait_reg    <= wait_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            slave_reg   <= slave_next;
            regaddr_reg <= regaddr_next;
            data_reg    <= data_next;
            is_read_reg <= is_read_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            status_reg  <= status_next;
        end
    end

    // Output register: load on every accepted tick, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
            res_reg <= res_next;
    end

    `ASSERT_IMPLY(a_done_not_busy, res_valid_reg && res_reg.done_res, !res_reg.busy_res)
    `ASSERT_IMPLY(a_status_only_done, res_valid_reg && !res_reg.done_res,
                  res_reg.status == i2cm_pkg::ST_OK)
    `ASSERT_IMPLY(a_wait_only_busy, wait_reg != '0, !idle)
    `ASSERT_CLK(a_bit_cnt_range, bit_cnt_reg <= i2cm_pkg::BYTE_BITS)

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_TICKS   = 40;

    // Tracks the sequencer tick by tick and holds the result (bus drive, busy, done,
    // status, read data) expected for every accepted tick until the matching result transfer arrives.
    class i2c_access_scoreboard;
        logic [15:0]                      hp;
        i2cm_pkg::phase_t                 ph;
        logic [2:0]                       sub;
        logic [i2cm_pkg::COUNT_WIDTH-1:0] wait_cnt;
        logic [3:0]                       nbits;
        logic [7:0]                       shreg;
        logic [7:0]                       slave;
        logic [7:0]                       regad;
        logic [7:0]                       wdata;
        logic                             rd;
        logic                             scl;
        logic                             sda_lvl;
        logic [1:0]                       stat;
        int                               mismatches;
        i2cm_pkg::res_t                   bus_outcomes[$];

        function new();
            hp = i2cm_pkg::HALF_PERIOD_RESET;
            ph = i2cm_pkg::P_CTRL;
            sub = 3'd0;
            wait_cnt = '0;
            nbits = '0;
            shreg = '0;
            slave = '0;
            regad = '0;
            wdata = '0;
            rd = 1'b0;
            scl = 1'b1;
            sda_lvl = 1'b1;
            stat = i2cm_pkg::ST_OK;
            mismatches = 0;
        endfunction

        function bit idle();
            return ph == i2cm_pkg::P_CTRL && sub == 3'd0;
        endfunction

        // Change the lines, then hold for a half period.
        function void put_lines(logic c, logic d, i2cm_pkg::phase_t p, logic [2:0] s);
            scl = c;
            sda_lvl = d;
            wait_cnt = i2cm_pkg::COUNT_WIDTH'(hp);
            ph = p;
            sub = s;
        endfunction

        function void load_byte(i2cm_pkg::phase_t p, logic [7:0] b);
            shreg = b;
            nbits = '0;
            ph = p;
            sub = 3'd0;
        endfunction

        // Step through instant actions until one line change; returns 1 on completion.
        function bit run_sequencer(logic s);
            for (int guard = 0; guard < 8; guard++)
            begin
                case (ph)
                    i2cm_pkg::P_CTRL:
                    begin
                        case (sub)
                            3'd0: return 1'b0;
                            3'd1:
                            begin
                                put_lines(1'b0, sda_lvl, i2cm_pkg::P_CTRL, 3'd2);
                                return 1'b0;
                            end
                            3'd2:
                            begin
                                put_lines(scl, 1'b0, i2cm_pkg::P_CTRL, 3'd3);
                                return 1'b0;
                            end
                            3'd3:
                            begin
                                put_lines(1'b1, sda_lvl, i2cm_pkg::P_CTRL, 3'd4);
                                return 1'b0;
                            end
                            3'd4:
                            begin
                                put_lines(scl, 1'b1, i2cm_pkg::P_CTRL, 3'd5);
                                return 1'b0;
                            end
                            default:
                            begin
                                sub = 3'd0;
                                return 1'b1;
                            end
                        endcase
                    end
                    i2cm_pkg::P_START, i2cm_pkg::P_RSTART:
                    begin
                        if (sub == 3'd0)
                        begin
                            put_lines(1'b1, 1'b1, ph, 3'd1);
                            return 1'b0;
                        end
                        if ((sub == 3'd1 && !s) || (sub == 3'd2 && s))
                        begin
                            if (ph == i2cm_pkg::P_START)
                            begin
                                stat = (sub == 3'd1) ? i2cm_pkg::ST_BUS_BUSY
                                                     : i2cm_pkg::ST_BUS_ERROR;
                                ph = i2cm_pkg::P_CTRL;
                                sub = 3'd0;
                                return 1'b1;
                            end
                            // a failed repeated start is ignored
                            load_byte(i2cm_pkg::P_RADDR, slave + 8'd1);
                        end
                        else if (sub == 3'd1 || sub == 3'd2)
                        begin
                            put_lines(scl, 1'b0, ph, sub + 3'd1);
                            return 1'b0;
                        end
                        else if (ph == i2cm_pkg::P_START)
                        begin
                            load_byte(i2cm_pkg::P_ADDR, slave);
                        end
                        else
                        begin
                            load_byte(i2cm_pkg::P_RADDR, slave + 8'd1);
                        end
                    end
                    i2cm_pkg::P_READ:
                    begin
                        case (sub)
                            3'd0:
                            begin
                                put_lines(1'b0, 1'b1, i2cm_pkg::P_READ, 3'd1);
                                return 1'b0;
                            end
                            3'd1:
                            begin
                                put_lines(1'b1, sda_lvl, i2cm_pkg::P_READ, 3'd2);
                                return 1'b0;
                            end
                            3'd2:
                            begin
                                shreg = {shreg[6:0], s};
                                nbits++;
                                sub = (nbits >= i2cm_pkg::BYTE_BITS) ? 3'd3 : 3'd0;
                            end
                            3'd3:
                            begin
                                put_lines(1'b0, sda_lvl, i2cm_pkg::P_READ, 3'd4);
                                return 1'b0;
                            end
                            3'd4:
                            begin
                                put_lines(scl, 1'b1, i2cm_pkg::P_READ, 3'd5);
                                return 1'b0;
                            end
                            3'd5:
                            begin
                                put_lines(1'b1, sda_lvl, i2cm_pkg::P_READ, 3'd6);
                                return 1'b0;
                            end
                            3'd6:
                            begin
                                put_lines(1'b0, sda_lvl, i2cm_pkg::P_CTRL, 3'd1);
                                return 1'b0;
                            end
                            default:
                            begin
                                ph = i2cm_pkg::P_CTRL;
                                sub = 3'd1;
                            end
                        endcase
                    end
                    default:
                    begin
                        case (sub)
                            3'd0:
                            begin
                                put_lines(1'b0, sda_lvl, ph, 3'd1);
                                return 1'b0;
                            end
                            3'd1:
                            begin
                                put_lines(scl, shreg[7], ph, 3'd2);
                                shreg = shreg << 1;
                                return 1'b0;
                            end
                            3'd2:
                            begin
                                nbits++;
                                put_lines(1'b1, sda_lvl, ph,
                                          (nbits >= i2cm_pkg::BYTE_BITS) ? 3'd3 : 3'd0);
                                return 1'b0;
                            end
                            3'd3:
                            begin
                                put_lines(1'b0, sda_lvl, ph, 3'd4);
                                return 1'b0;
                            end
                            3'd4:
                            begin
                                put_lines(scl, 1'b1, ph, 3'd5);
                                return 1'b0;
                            end
                            3'd5:
                            begin
                                put_lines(1'b1, sda_lvl, ph, 3'd6);
                                return 1'b0;
                            end
                            3'd6:
                            begin
                                // only the first address acknowledge counts
                                if (ph == i2cm_pkg::P_ADDR && s)
                                    stat = i2cm_pkg::ST_ADDR_NACK;
                                put_lines(1'b0, sda_lvl, ph, 3'd7);
                                return 1'b0;
                            end
                            default:
                            begin
                                case (ph)
                                    i2cm_pkg::P_ADDR:
                                    begin
                                        if (stat == i2cm_pkg::ST_ADDR_NACK)
                                        begin
                                            ph = i2cm_pkg::P_CTRL;
                                            sub = 3'd1;
                                        end
                                        else
                                        begin
                                            load_byte(i2cm_pkg::P_REG, regad);
                                        end
                                    end
                                    i2cm_pkg::P_REG:
                                    begin
                                        if (rd)
                                        begin
                                            ph = i2cm_pkg::P_RSTART;
                                            sub = 3'd0;
                                        end
                                        else
                                        begin
                                            load_byte(i2cm_pkg::P_DATA, wdata);
                                        end
                                    end
                                    i2cm_pkg::P_DATA:
                                    begin
                                        ph = i2cm_pkg::P_CTRL;
                                        sub = 3'd1;
                                    end
                                    default:
                                    begin
                                        shreg = '0;
                                        nbits = '0;
                                        ph = i2cm_pkg::P_READ;
                                        sub = 3'd0;
                                    end
                                endcase
                            end
                        endcase
                    end
                endcase
            end
            return 1'b0;
        endfunction

        function void note_tick(i2cm_pkg::cmd_t c);
            i2cm_pkg::res_t r;
            bit             done;
            done = 1'b0;
            if (idle())
            begin
                if (c.command == i2cm_pkg::CMD_WRITE || c.command == i2cm_pkg::CMD_READ)
                begin
                    slave = c.slave_address;
                    regad = c.reg_index;
                    wdata = c.write_data;
                    rd = (c.command == i2cm_pkg::CMD_READ);
                    stat = i2cm_pkg::ST_OK;
                    shreg = '0;
                    nbits = '0;
                    ph = i2cm_pkg::P_START;
                    sub = 3'd0;
                    done = run_sequencer(c.sda_in);
                end
            end
            else if (wait_cnt != '0)
            begin
                wait_cnt--;
            end
            else
            begin
                done = run_sequencer(c.sda_in);
            end
            r.scl_out = scl;
            r.sda_out = sda_lvl;
            r.busy_res = !idle();
            r.done_res = done;
            r.status = done ? stat : i2cm_pkg::ST_OK;
            r.read_data = (done && rd && stat == i2cm_pkg::ST_OK) ? shreg : 8'h00;
            bus_outcomes.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(i2cm_pkg::res_t r);
            i2cm_pkg::res_t want;
            if (bus_outcomes.size() == 0)
            begin
                $display("%0t: result expected none actual %p", $time, r);
                mismatches++;
                return;
            end
            want = bus_outcomes.pop_front();
            compare_field("scl_out", 8'(want.scl_out), 8'(r.scl_out));
            compare_field("sda_out", 8'(want.sda_out), 8'(r.sda_out));
            compare_field("busy_res", 8'(want.busy_res), 8'(r.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(r.done_res));
            compare_field("status", 8'(want.status), 8'(r.status));
            compare_field("read_data", want.read_data, r.read_data);
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [15:0]    cfg_data = '0;
    logic           cmd_valid = 1'b0;
    logic           cmd_stall;
    i2cm_pkg::cmd_t cmd_data = '0;
    logic           res_valid;
    logic           res_stall = 1'b0;
    i2cm_pkg::res_t res_data;

    i2c_access_scoreboard sb = new();

    int unsigned sender_idle = 0;
    int unsigned receiver_stall = 0;
    int          quiet_cycles = 0;

    // how the simulated slave answers at each bus sample
    logic [1:0] start_fault = i2cm_pkg::ST_OK;
    logic [1:0] rstart_fault = i2cm_pkg::ST_OK;
    bit         nack_addr = 1'b0;
    logic [7:0] read_pattern = '0;
    bit         sda_noise = 1'b0;
    bit         busy_requests = 1'b0;

    i2c_master_register_access_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(99) < receiver_stall);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_data);
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic pick_sda();
        if (sda_noise)
            return 1'($urandom_range(1));
        case (sb.ph)
            i2cm_pkg::P_START:
            begin
                if (sb.sub == 3'd1) return start_fault != i2cm_pkg::ST_BUS_BUSY;
                if (sb.sub == 3'd2) return start_fault == i2cm_pkg::ST_BUS_ERROR;
            end
            i2cm_pkg::P_RSTART:
            begin
                if (sb.sub == 3'd1) return rstart_fault != i2cm_pkg::ST_BUS_BUSY;
                if (sb.sub == 3'd2) return rstart_fault == i2cm_pkg::ST_BUS_ERROR;
            end
            i2cm_pkg::P_ADDR:
            begin
                if (sb.sub == 3'd6) return nack_addr;
            end
            i2cm_pkg::P_READ:
            begin
                if (sb.sub == 3'd2) return read_pattern[3'd7 - sb.nbits[2:0]];
            end
            default: ;
        endcase
        return 1'($urandom_range(1));
    endfunction

    function automatic i2cm_pkg::cmd_t busy_tick();
        i2cm_pkg::cmd_t c;
        c.command = busy_requests ? 2'($urandom_range(3)) : i2cm_pkg::CMD_NONE;
        c.slave_address = 8'($urandom);
        c.reg_index = 8'($urandom);
        c.write_data = 8'($urandom);
        c.sda_in = pick_sda();
        return c;
    endfunction

    function automatic i2cm_pkg::cmd_t random_tick();
        i2cm_pkg::cmd_t c;
        int             n;
        busy_requests = ($urandom_range(9) == 0);
        c = busy_tick();
        if (sb.idle())
        begin
            n = int'($urandom_range(99));
            if (n < 30)
                c.command = i2cm_pkg::CMD_WRITE;
            else if (n < 60)
                c.command = i2cm_pkg::CMD_READ;
            else if (n < 66)
                c.command = CMD_UNUSED;
            else
                c.command = i2cm_pkg::CMD_NONE;
            // new plan for the slave side of the next transaction
            n = int'($urandom_range(99));
            start_fault = (n < 8) ? i2cm_pkg::ST_BUS_BUSY
                        : (n < 16) ? i2cm_pkg::ST_BUS_ERROR : i2cm_pkg::ST_OK;
            n = int'($urandom_range(99));
            rstart_fault = (n < 10) ? i2cm_pkg::ST_BUS_BUSY
                         : (n < 20) ? i2cm_pkg::ST_BUS_ERROR : i2cm_pkg::ST_OK;
            nack_addr = ($urandom_range(99) < 15);
            read_pattern = 8'($urandom);
            sda_noise = ($urandom_range(99) < 8);
        end
        return c;
    endfunction

    task automatic send_tick(i2cm_pkg::cmd_t c);
        bit taken;
        while ($urandom_range(99) < sender_idle)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            if (!cmd_stall)
            begin
                taken = 1'b1;
                sb.note_tick(c);
            end
            @(negedge clk);
        end
    endtask

    // Run the sequencer back to idle, then drain every pending result.
    task automatic quiesce();
        while (!sb.idle())
            send_tick(busy_tick());
        cmd_valid <= 1'b0;
        while (sb.bus_outcomes.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_half_period(logic [15:0] v);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.hp = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic request(logic [1:0] op, logic [7:0] sa, logic [7:0] ra, logic [7:0] wd,
                           logic [1:0] sf, bit nack, logic [1:0] rf, logic [7:0] pattern);
        i2cm_pkg::cmd_t c;
        start_fault = sf;
        nack_addr = nack;
        rstart_fault = rf;
        read_pattern = pattern;
        c = busy_tick();
        c.command = op;
        c.slave_address = sa;
        c.reg_index = ra;
        c.write_data = wd;
        send_tick(c);
        quiesce();
    endtask

    task automatic random_phase(logic [15:0] v, int unsigned idle_pct,
                                int unsigned stall_pct);
        i2cm_pkg::cmd_t c;
        int             ticks;
        set_half_period(v);
        sender_idle = idle_pct;
        receiver_stall = stall_pct;
        ticks = 0;
        while (ticks < RANDOM_TICKS)
        begin
            c = random_tick();
            send_tick(c);
            ticks++;
        end
        busy_requests = 1'b0;
        sda_noise = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // start error at the reset half period
        request(i2cm_pkg::CMD_READ, 8'hFF, 8'hFF, 8'hFF, i2cm_pkg::ST_BUS_ERROR, 1'b0,
                i2cm_pkg::ST_OK, 8'h00);

        set_half_period(16'd0);
        // requests arriving mid-transaction must be dropped
        busy_requests = 1'b1;
        request(i2cm_pkg::CMD_WRITE, 8'hFF, 8'hFF, 8'hFF, i2cm_pkg::ST_OK, 1'b0,
                i2cm_pkg::ST_OK, 8'h00);
        busy_requests = 1'b0;
        // address plus one wraps to zero, failed repeated start is ignored
        request(i2cm_pkg::CMD_READ, 8'hFF, 8'h5A, 8'h00, i2cm_pkg::ST_OK, 1'b0,
                i2cm_pkg::ST_BUS_ERROR, 8'hA5);
        request(CMD_UNUSED, 8'h12, 8'h34, 8'h56, i2cm_pkg::ST_OK, 1'b0,
                i2cm_pkg::ST_OK, 8'h00);
        request(i2cm_pkg::CMD_NONE, 8'hAB, 8'hCD, 8'hEF, i2cm_pkg::ST_OK, 1'b0,
                i2cm_pkg::ST_OK, 8'h00);
        request(i2cm_pkg::CMD_WRITE, 8'hA0, 8'h01, 8'h02, i2cm_pkg::ST_BUS_BUSY, 1'b0,
                i2cm_pkg::ST_OK, 8'h00);
        request(i2cm_pkg::CMD_READ, 8'h3C, 8'hC3, 8'h99, i2cm_pkg::ST_OK, 1'b1,
                i2cm_pkg::ST_OK, 8'h77);

        random_phase(16'd1, 0, 0);
        random_phase(16'd0, 77, 0);
        random_phase(16'd1, 0, 77);
        random_phase(16'd0, 27, 27);

        sender_idle = 0;
        receiver_stall = 0;
        set_half_period(16'd60);
        request(i2cm_pkg::CMD_WRITE, 8'h5A, 8'hA5, 8'h0F, i2cm_pkg::ST_BUS_BUSY, 1'b0,
                i2cm_pkg::ST_OK, 8'h00);

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.bus_outcomes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/i2cm_pkg.sv
sv/i2c_master_register_access_core.sv
tb/tb_top.sv
